// ----- sv/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AAT_ASSERT(label, clk, rst_n, prop, msg)

`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/aat_pkg.sv -----
package aat_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int COEF_WIDTH    = 32;
    localparam int CFG_WIDTH     = 2 * COEF_WIDTH;
    localparam int NUM_REGS      = 6;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_ROWS      = 3;
    localparam int NUM_AXES      = 3;
    localparam int NUM_STAGES    = 5;

    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int TRANS_WIDTH = COEF_WIDTH + FRAC_BITS;
    localparam int SUM_WIDTH   = ((PROD_WIDTH > TRANS_WIDTH) ? PROD_WIDTH : TRANS_WIDTH) + 2;
    localparam int SHIFT_WIDTH = SUM_WIDTH - FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [CFG_WIDTH-1:0]          cfg_word_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } cfg_idx_t;

    localparam coef_t COEF_ZERO = '0;
    localparam coef_t COEF_ONE  = coef_t'(1) <<< FRAC_BITS;

    // The reset matrix is the identity transform.
    localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
        {COEF_ZERO, COEF_ONE},
        {COEF_ZERO, COEF_ZERO},
        {COEF_ONE,  COEF_ZERO},
        {COEF_ZERO, COEF_ZERO},
        {COEF_ZERO, COEF_ZERO},
        {COEF_ZERO, COEF_ONE}
    };

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic   sat;
        coord_t value;
    } fin_t;

    // Drops the fraction bits with floor rounding and clamps to the coordinate range.
    function automatic fin_t finish_coord(input sum_t s);
        sum_t                                 sh;
        logic [SHIFT_WIDTH-COORD_WIDTH:0]     top;
        fin_t                                 r;
        sh    = s >>> FRAC_BITS;
        top   = sh[SHIFT_WIDTH-1:COORD_WIDTH-1];
        r.sat = !((&top) || !(|top));
        if (r.sat)
        begin
            r.value = s[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r.value = sh[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/aat_intf.sv -----
interface aat_box_if import aat_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aat_res_if import aat_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t out_lo_x;
    coord_t out_lo_y;
    coord_t out_lo_z;
    coord_t out_hi_x;
    coord_t out_hi_y;
    coord_t out_hi_z;
    logic   clipped;

    modport source (output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                    out_hi_z, clipped, input ready);
    modport sink (input valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                  out_hi_z, clipped, output ready);
endinterface

interface aat_cfg_if import aat_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    cfg_word_t                data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/aat_cfg_regs.sv -----
module aat_cfg_regs import aat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    aat_cfg_if.sink   cfg,
    output coef_t     coef [NUM_ROWS][NUM_AXES],
    output coef_t     trans [NUM_ROWS]
);

    cfg_word_t regs_reg [NUM_REGS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01,
                REG_ROW1_COLS23, REG_ROW2_COLS01, REG_ROW2_COLS23:
                begin
                    regs_reg[cfg.index] <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign coef[0][0] = regs_reg[REG_ROW0_COLS01][COEF_WIDTH-1:0];
    assign coef[0][1] = regs_reg[REG_ROW0_COLS01][CFG_WIDTH-1:COEF_WIDTH];
    assign coef[0][2] = regs_reg[REG_ROW0_COLS23][COEF_WIDTH-1:0];
    assign trans[0]   = regs_reg[REG_ROW0_COLS23][CFG_WIDTH-1:COEF_WIDTH];
    assign coef[1][0] = regs_reg[REG_ROW1_COLS01][COEF_WIDTH-1:0];
    assign coef[1][1] = regs_reg[REG_ROW1_COLS01][CFG_WIDTH-1:COEF_WIDTH];
    assign coef[1][2] = regs_reg[REG_ROW1_COLS23][COEF_WIDTH-1:0];
    assign trans[1]   = regs_reg[REG_ROW1_COLS23][CFG_WIDTH-1:COEF_WIDTH];
    assign coef[2][0] = regs_reg[REG_ROW2_COLS01][COEF_WIDTH-1:0];
    assign coef[2][1] = regs_reg[REG_ROW2_COLS01][CFG_WIDTH-1:COEF_WIDTH];
    assign coef[2][2] = regs_reg[REG_ROW2_COLS23][COEF_WIDTH-1:0];
    assign trans[2]   = regs_reg[REG_ROW2_COLS23][CFG_WIDTH-1:COEF_WIDTH];

endmodule

// ----- sv/aat_prod_stage.sv -----
module aat_prod_stage import aat_pkg::*;
(
    input  logic   clk,
    input  logic   adv,
    input  coord_t lo_in [NUM_AXES],
    input  coord_t hi_in [NUM_AXES],
    input  coef_t  coef [NUM_ROWS][NUM_AXES],
    output prod_t  mn_reg [NUM_ROWS][NUM_AXES],
    output prod_t  mx_reg [NUM_ROWS][NUM_AXES]
);

    coord_t lo_reg [NUM_AXES];
    coord_t hi_reg [NUM_AXES];
    prod_t  lprod_reg [NUM_ROWS][NUM_AXES];
    prod_t  hprod_reg [NUM_ROWS][NUM_AXES];
    prod_t  lprod_next [NUM_ROWS][NUM_AXES];
    prod_t  hprod_next [NUM_ROWS][NUM_AXES];
    prod_t  mn_next [NUM_ROWS][NUM_AXES];
    prod_t  mx_next [NUM_ROWS][NUM_AXES];

    // Each coefficient meets only the low or the high coordinate of its axis,
    // so eighteen products cover all eight corners.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                lprod_next[r][c] = prod_t'(coef[r][c]) * prod_t'(lo_reg[c]);
                hprod_next[r][c] = prod_t'(coef[r][c]) * prod_t'(hi_reg[c]);
                if (lprod_reg[r][c] < hprod_reg[r][c])
                begin
                    mn_next[r][c] = lprod_reg[r][c];
                    mx_next[r][c] = hprod_reg[r][c];
                end
                else
                begin
                    mn_next[r][c] = hprod_reg[r][c];
                    mx_next[r][c] = lprod_reg[r][c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg    <= lo_in;
            hi_reg    <= hi_in;
            lprod_reg <= lprod_next;
            hprod_reg <= hprod_next;
            mn_reg    <= mn_next;
            mx_reg    <= mx_next;
        end
    end

endmodule

// ----- sv/aat_sum_stage.sv -----
module aat_sum_stage import aat_pkg::*;
(
    input  logic   clk,
    input  logic   adv,
    input  prod_t  mn_in [NUM_ROWS][NUM_AXES],
    input  prod_t  mx_in [NUM_ROWS][NUM_AXES],
    input  coef_t  trans [NUM_ROWS],
    output coord_t lo_out_reg [NUM_ROWS],
    output coord_t hi_out_reg [NUM_ROWS],
    output logic   clipped_reg
);

    sum_t   lo_a_reg [NUM_ROWS];
    sum_t   lo_b_reg [NUM_ROWS];
    sum_t   hi_a_reg [NUM_ROWS];
    sum_t   hi_b_reg [NUM_ROWS];
    sum_t   lo_a_next [NUM_ROWS];
    sum_t   lo_b_next [NUM_ROWS];
    sum_t   hi_a_next [NUM_ROWS];
    sum_t   hi_b_next [NUM_ROWS];
    sum_t   t_ext [NUM_ROWS];
    fin_t   lo_fin [NUM_ROWS];
    fin_t   hi_fin [NUM_ROWS];
    coord_t lo_out_next [NUM_ROWS];
    coord_t hi_out_next [NUM_ROWS];
    logic   clipped_next;

    // Rounding and clamping are monotonic, so the extreme corners give the
    // extreme results, and a clamp on any corner shows on one of them.
    always_comb
    begin
        clipped_next = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            t_ext[r]     = sum_t'(trans[r]) <<< FRAC_BITS;
            lo_a_next[r] = t_ext[r] + sum_t'(mn_in[r][0]);
            lo_b_next[r] = sum_t'(mn_in[r][1]) + sum_t'(mn_in[r][2]);
            hi_a_next[r] = t_ext[r] + sum_t'(mx_in[r][0]);
            hi_b_next[r] = sum_t'(mx_in[r][1]) + sum_t'(mx_in[r][2]);
            lo_fin[r]    = finish_coord(lo_a_reg[r] + lo_b_reg[r]);
            hi_fin[r]    = finish_coord(hi_a_reg[r] + hi_b_reg[r]);
            lo_out_next[r] = lo_fin[r].value;
            hi_out_next[r] = hi_fin[r].value;
            clipped_next = clipped_next | lo_fin[r].sat | hi_fin[r].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_a_reg    <= lo_a_next;
            lo_b_reg    <= lo_b_next;
            hi_a_reg    <= hi_a_next;
            hi_b_reg    <= hi_b_next;
            lo_out_reg  <= lo_out_next;
            hi_out_reg  <= hi_out_next;
            clipped_reg <= clipped_next;
        end
    end

endmodule

// ----- sv/aabb_affine_transform.sv -----
// Pipeline: a box word accepted at a clock edge passes through five register
// stages, with the result register last, to reach the result port.
// Throughput: one box word per cycle; the whole pipeline holds while a result waits.
// Reset: the asynchronous active-low reset clears all stage valid bits and loads the
// identity matrix; configuration words are taken at any time.
`include "assert_macros.svh"

module aabb_affine_transform import aat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    aat_cfg_if.sink    cfg,
    aat_box_if.sink    box,
    aat_res_if.source  result
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  adv;
    coef_t                 coef [NUM_ROWS][NUM_AXES];
    coef_t                 trans [NUM_ROWS];
    coord_t                lo_in [NUM_AXES];
    coord_t                hi_in [NUM_AXES];
    prod_t                 mn [NUM_ROWS][NUM_AXES];
    prod_t                 mx [NUM_ROWS][NUM_AXES];
    coord_t                lo_out [NUM_ROWS];
    coord_t                hi_out [NUM_ROWS];
    logic                  clipped;
    logic                  result_ordered;

    assign adv       = !valid_reg[NUM_STAGES-1] || result.ready;
    assign box.ready = adv;

    assign lo_in[0] = box.lo_x;
    assign lo_in[1] = box.lo_y;
    assign lo_in[2] = box.lo_z;
    assign hi_in[0] = box.hi_x;
    assign hi_in[1] = box.hi_y;
    assign hi_in[2] = box.hi_z;

    always_comb
    begin
        valid_next = {valid_reg[NUM_STAGES-2:0], box.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    aat_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef),
        .trans (trans)
    );

    aat_prod_stage u_prod_stage (
        .clk    (clk),
        .adv    (adv),
        .lo_in  (lo_in),
        .hi_in  (hi_in),
        .coef   (coef),
        .mn_reg (mn),
        .mx_reg (mx)
    );

    aat_sum_stage u_sum_stage (
        .clk         (clk),
        .adv         (adv),
        .mn_in       (mn),
        .mx_in       (mx),
        .trans       (trans),
        .lo_out_reg  (lo_out),
        .hi_out_reg  (hi_out),
        .clipped_reg (clipped)
    );

    assign result.valid    = valid_reg[NUM_STAGES-1];
    assign result.out_lo_x = lo_out[0];
    assign result.out_lo_y = lo_out[1];
    assign result.out_lo_z = lo_out[2];
    assign result.out_hi_x = hi_out[0];
    assign result.out_hi_y = hi_out[1];
    assign result.out_hi_z = hi_out[2];
    assign result.clipped  = clipped;

    assign result_ordered = (result.out_lo_x <= result.out_hi_x)
                            && (result.out_lo_y <= result.out_hi_y)
                            && (result.out_lo_z <= result.out_hi_z);

    `AAT_ASSERT(a_lo_le_hi, clk, rst_n, !result.valid || result_ordered, "Result minimum exceeds maximum.")
    `AAT_ASSERT(a_no_take_on_stall, clk, rst_n, !(result.valid && !result.ready) || !box.ready, "Box taken while the result is stalled.")
    `AAT_ASSERT_NEXT(a_take_enters, clk, rst_n, box.valid && box.ready, valid_reg[0], "Accepted box did not enter the pipeline.")
    `AAT_ASSERT_NEXT(a_last_reaches_out, clk, rst_n, valid_reg[NUM_STAGES-2] && adv, result.valid, "Pipeline word lost before the result register.")

endmodule

// ----- dv/aabb_affine_transform_test.sv -----
`timescale 1ns / 1ps

module aabb_affine_transform_test;
    import aat_pkg::*;

    localparam int ONE_Q            = 1 << FRAC_BITS;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_BOXES      = 124;

    localparam logic [CFG_IDX_WIDTH-1:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_UNUSED_HI = 3'd7;

    localparam coef_t COEF_MOST  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t COEF_LEAST = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    typedef logic signed [COORD_WIDTH+COEF_WIDTH+7:0] wide_t;

    typedef struct {
        coord_t lo [NUM_AXES];
        coord_t hi [NUM_AXES];
    } box_t;

    typedef struct {
        coord_t lo [NUM_AXES];
        coord_t hi [NUM_AXES];
        logic   clipped;
    } mapped_box_t;

    class aabb_ledger;
        cfg_word_t   regs [NUM_REGS];
        mapped_box_t pending_boxes [$];
        int          mismatches;
        int          boxes_checked;
        int          clipped_boxes;

        function new();
            regs[REG_ROW0_COLS01] = {COEF_ZERO, COEF_ONE};
            regs[REG_ROW0_COLS23] = {COEF_ZERO, COEF_ZERO};
            regs[REG_ROW1_COLS01] = {COEF_ONE, COEF_ZERO};
            regs[REG_ROW1_COLS23] = {COEF_ZERO, COEF_ZERO};
            regs[REG_ROW2_COLS01] = {COEF_ZERO, COEF_ZERO};
            regs[REG_ROW2_COLS23] = {COEF_ZERO, COEF_ONE};
            mismatches    = 0;
            boxes_checked = 0;
            clipped_boxes = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_WIDTH-1:0] idx, cfg_word_t data);
            if (idx < NUM_REGS)
            begin
                regs[idx] = data;
            end
        endfunction

        function void map_corner(input coord_t p [NUM_AXES], output coord_t q [NUM_AXES],
                                 inout bit sat);
            wide_t acc;
            coef_t m0, m1, m2, t;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                m0  = regs[2*r][COEF_WIDTH-1:0];
                m1  = regs[2*r][CFG_WIDTH-1:COEF_WIDTH];
                m2  = regs[2*r+1][COEF_WIDTH-1:0];
                t   = regs[2*r+1][CFG_WIDTH-1:COEF_WIDTH];
                acc = (wide_t'(t) <<< FRAC_BITS) + wide_t'(m0) * wide_t'(p[0])
                      + wide_t'(m1) * wide_t'(p[1]) + wide_t'(m2) * wide_t'(p[2]);
                acc = acc >>> FRAC_BITS;
                if (acc > wide_t'(COORD_MAX))
                begin
                    q[r] = COORD_MAX;
                    sat  = 1'b1;
                end
                else if (acc < wide_t'(COORD_MIN))
                begin
                    q[r] = COORD_MIN;
                    sat  = 1'b1;
                end
                else
                begin
                    q[r] = acc[COORD_WIDTH-1:0];
                end
            end
        endfunction

        function mapped_box_t map_box(box_t b);
            mapped_box_t m;
            coord_t      p [NUM_AXES];
            coord_t      q [NUM_AXES];
            bit          sat;
            sat = 1'b0;
            for (int c = 0; c < 8; c++)
            begin
                p[0] = ((c & 4) != 0) ? b.hi[0] : b.lo[0];
                p[1] = ((c & 2) != 0) ? b.hi[1] : b.lo[1];
                p[2] = ((c & 1) != 0) ? b.hi[2] : b.lo[2];
                map_corner(p, q, sat);
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if (c == 0 || q[a] < m.lo[a])
                    begin
                        m.lo[a] = q[a];
                    end
                    if (c == 0 || q[a] > m.hi[a])
                    begin
                        m.hi[a] = q[a];
                    end
                end
            end
            m.clipped = sat;
            return m;
        endfunction

        function void note_box(box_t b);
            pending_boxes.push_back(map_box(b));
        endfunction

        function void check_result(mapped_box_t got);
            mapped_box_t want;
            string       names;
            names = "xyz";
            if (pending_boxes.size() == 0)
            begin
                $display("%0t: result with no box outstanding", $time);
                mismatches++;
                return;
            end
            want = pending_boxes.pop_front();
            boxes_checked++;
            if (want.clipped)
            begin
                clipped_boxes++;
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (got.lo[a] !== want.lo[a])
                begin
                    $display("%0t: out_lo_%c expected %0d, got %0d", $time, names[a],
                             want.lo[a], got.lo[a]);
                    mismatches++;
                end
                if (got.hi[a] !== want.hi[a])
                begin
                    $display("%0t: out_hi_%c expected %0d, got %0d", $time, names[a],
                             want.hi[a], got.hi[a]);
                    mismatches++;
                end
            end
            if (got.clipped !== want.clipped)
            begin
                $display("%0t: clipped expected %0b, got %0b", $time, want.clipped,
                         got.clipped);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_boxes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    aat_cfg_if cfg_if ();
    aat_box_if box_if ();
    aat_res_if res_if ();

    aabb_affine_transform dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .box    (box_if),
        .result (res_if)
    );

    aabb_ledger ledger;
    bit         sender_steady;
    bit         receiver_steady;
    bit         long_hold;
    int         settings_applied;
    int         quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (box_if.valid && box_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int idle_gap(bit steady);
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(3, 1);
        end
        if (roll < 97)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic coord_t rand_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            return coord_t'(int'($urandom_range(1 << 27)) - (1 << 26));
        end
        if (roll < 75)
        begin
            return coord_t'(int'($urandom_range(1 << 19)) - (1 << 18));
        end
        if (roll < 90)
        begin
            return coord_t'($urandom);
        end
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return coord_t'(0);
            default: return coord_t'(-1);
        endcase
    endfunction

    function automatic coef_t rand_coef();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            return coef_t'(int'($urandom_range(8 * ONE_Q)) - 4 * ONE_Q);
        end
        if (roll < 60)
        begin
            return COEF_ZERO;
        end
        if (roll < 70)
        begin
            return ($urandom_range(1) != 0) ? COEF_ONE : -COEF_ONE;
        end
        if (roll < 85)
        begin
            return coef_t'($urandom);
        end
        if (roll < 95)
        begin
            return coef_t'(int'($urandom_range(1 << 13)) - (1 << 12));
        end
        return ($urandom_range(1) != 0) ? COEF_MOST : COEF_LEAST;
    endfunction

    function automatic box_t rand_box();
        box_t   b;
        coord_t u, v;
        int     roll;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            u    = rand_coord();
            v    = rand_coord();
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                b.lo[a] = (u < v) ? u : v;
                b.hi[a] = (u < v) ? v : u;
            end
            else if (roll < 88)
            begin
                b.lo[a] = u;
                b.hi[a] = u;
            end
            else
            begin
                b.lo[a] = u;
                b.hi[a] = v;
            end
        end
        return b;
    endfunction

    function automatic box_t make_box(coord_t lx, coord_t ly, coord_t lz,
                                      coord_t hx, coord_t hy, coord_t hz);
        box_t b;
        b.lo[0] = lx;
        b.lo[1] = ly;
        b.lo[2] = lz;
        b.hi[0] = hx;
        b.hi[1] = hy;
        b.hi[2] = hz;
        return b;
    endfunction

    function automatic cfg_word_t pack_coefs(coef_t first, coef_t second);
        return {second, first};
    endfunction

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, cfg_word_t data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        ledger.load_reg(idx, data);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic load_matrix(cfg_word_t words [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            write_reg(cfg_idx_t'(i), words[i]);
        end
        settings_applied++;
    endtask

    task automatic send_box(box_t b);
        int gap;
        box_if.lo_x  = b.lo[0];
        box_if.lo_y  = b.lo[1];
        box_if.lo_z  = b.lo[2];
        box_if.hi_x  = b.hi[0];
        box_if.hi_y  = b.hi[1];
        box_if.hi_z  = b.hi[2];
        box_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!box_if.ready);
        ledger.note_box(b);
        @(negedge clk);
        gap = idle_gap(sender_steady);
        if (gap > 0)
        begin
            box_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        box_if.valid = 1'b0;
        while (ledger.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(int n_boxes, bit hold);
        cfg_word_t words [NUM_REGS];
        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            words[i] = pack_coefs(rand_coef(), rand_coef());
        end
        load_matrix(words);
        if ($urandom_range(2) == 0)
        begin
            write_reg(($urandom_range(1) != 0) ? IDX_UNUSED_HI : IDX_UNUSED_LO,
                      {$urandom, $urandom});
        end
        long_hold = hold;
        for (int n = 0; n < n_boxes; n++)
        begin
            send_box(rand_box());
        end
    endtask

    initial
    begin
        mapped_box_t got;
        int          gap;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = idle_gap(receiver_steady);
            if (gap > 0)
            begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_if.ready = 1'b1;
            @(posedge clk);
            if (res_if.valid)
            begin
                got.lo[0]   = res_if.out_lo_x;
                got.lo[1]   = res_if.out_lo_y;
                got.lo[2]   = res_if.out_lo_z;
                got.hi[0]   = res_if.out_hi_x;
                got.hi[1]   = res_if.out_hi_y;
                got.hi[2]   = res_if.out_hi_z;
                got.clipped = res_if.clipped;
                ledger.check_result(got);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        cfg_word_t words [NUM_REGS];
        ledger           = new();
        sender_steady    = 1'b0;
        receiver_steady  = 1'b0;
        long_hold        = 1'b0;
        settings_applied = 1;
        rst_n            = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        box_if.valid     = 1'b0;
        box_if.lo_x      = '0;
        box_if.lo_y      = '0;
        box_if.lo_z      = '0;
        box_if.hi_x      = '0;
        box_if.hi_y      = '0;
        box_if.hi_z      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Identity after reset: the zero box, the full range, an inverted box, a small box and a point.
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(5 * ONE_Q, ONE_Q, -2 * ONE_Q, -5 * ONE_Q, ONE_Q / 2, -3 * ONE_Q));
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        send_box(make_box(7 * ONE_Q, -3, 12345, 7 * ONE_Q, -3, 12345));

        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            words[i] = pack_coefs(COEF_MOST, COEF_MOST);
        end
        load_matrix(words);
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));

        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            words[i] = pack_coefs(COEF_LEAST, COEF_LEAST);
        end
        load_matrix(words);
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));

        // Axis swap, negative and fractional scales, and a translation at its extreme.
        drain();
        words[REG_ROW0_COLS01] = pack_coefs(COEF_ZERO, -COEF_ONE);
        words[REG_ROW0_COLS23] = pack_coefs(COEF_ZERO, 7 * ONE_Q / 2);
        words[REG_ROW1_COLS01] = pack_coefs(2 * ONE_Q, COEF_ZERO);
        words[REG_ROW1_COLS23] = pack_coefs(ONE_Q / 2, -(29 * ONE_Q / 4));
        words[REG_ROW2_COLS01] = pack_coefs(ONE_Q / 4, -(3 * ONE_Q / 2));
        words[REG_ROW2_COLS23] = pack_coefs(COEF_ONE, COEF_MOST);
        load_matrix(words);
        send_box(make_box(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q));
        send_box(make_box(4 * ONE_Q, -2 * ONE_Q, ONE_Q / 2, -3 * ONE_Q, -8 * ONE_Q, -ONE_Q / 2));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));

        // Writes past the last register must leave the matrix alone.
        drain();
        write_reg(IDX_UNUSED_LO, {$urandom, $urandom});
        write_reg(IDX_UNUSED_HI, {$urandom, $urandom});
        send_box(rand_box());
        send_box(make_box(ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, 2 * ONE_Q, 2 * ONE_Q));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sender_steady   = (phase == 2 || phase == 4 || phase == 7);
            receiver_steady = (phase == 2 || phase == 6);
            run_random_phase(PHASE_BOXES, phase == 4);
        end

        receiver_steady = 1'b1;
        drain();
        $display("Checked %0d transformed boxes under %0d matrix settings, %0d of them clipped.",
                 ledger.boxes_checked, settings_applied, ledger.clipped_boxes);
        $display("Stimulus covered extreme and inverted boxes, unused register writes and stalls.");
        if (ledger.mismatches == 0 && ledger.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
